// ===== sv/vhdma_pkg.sv =====
package vhdma_pkg;

  localparam int CYCLES_PER_BLOCK = 8;
  localparam int MAX_BLOCKS       = 128;
  localparam int CHARGE_FULL_W    = $clog2(CYCLES_PER_BLOCK * MAX_BLOCKS * 2 + 1);
  localparam int CHARGE_W         = (CHARGE_FULL_W > 12) ? CHARGE_FULL_W : 12;
  localparam int MAX_CYCLES       = 4095;

  localparam logic [7:0] LEN_MASK   = 8'h7F;
  localparam logic [7:0] NIB_MASK   = 8'hF0;
  localparam logic [7:0] BANK_MASK  = 8'h1F;
  localparam logic [7:0] BLANK_MODE = 8'h80;
  localparam logic [7:0] STATUS_IDLE = 8'hFF;

  typedef enum logic [2:0] {
    CMD_SRC_HI = 3'd0,
    CMD_SRC_LO = 3'd1,
    CMD_DST_HI = 3'd2,
    CMD_DST_LO = 3'd3,
    CMD_LENGTH = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_t;

  localparam logic CFG_COLOR_MODE   = 1'b0;
  localparam logic CFG_DOUBLE_SPEED = 1'b1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic color_mode;
    logic double_speed;
  } cfg_t;

  typedef struct packed {
    logic        transfer_valid;
    logic [15:0] src_addr;
    logic [12:0] dst_offset;
    logic [11:0] length_bytes;
    logic [11:0] cycles_added;
    logic [7:0]  status_byte;
    logic        busy_res;
  } res_t;

  function automatic logic [11:0] charge(input logic [7:0] blocks, input logic dbl);
    logic [CHARGE_W-1:0] c;
    c = CHARGE_W'(CYCLES_PER_BLOCK) * CHARGE_W'(blocks);
    if (dbl) c = c << 1;
    return (c > CHARGE_W'(MAX_CYCLES)) ? 12'hFFF : c[11:0];
  endfunction

endpackage

// ===== sv/vhdma_if.sv =====
interface vhdma_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data;

  modport source (output valid, command, data, input ready);
  modport sink   (input valid, command, data, output ready);
endinterface

interface vhdma_out_if;
  logic        valid;
  logic        ready;
  logic        transfer_valid;
  logic [15:0] src_addr;
  logic [12:0] dst_offset;
  logic [11:0] length_bytes;
  logic [11:0] cycles_added;
  logic [7:0]  status_byte;
  logic        busy_res;

  modport source (output valid, transfer_valid, src_addr, dst_offset, length_bytes,
                  cycles_added, status_byte, busy_res, input ready);
  modport sink   (input valid, transfer_valid, src_addr, dst_offset, length_bytes,
                  cycles_added, status_byte, busy_res, output ready);
endinterface

// ===== sv/vram_hdma_controller.sv =====
// Video-RAM HDMA controller: takes one word per clock while ready is high (register write or
// blank tick) and returns one result word per input word, in order, through the input register
// and then the output register. The length/status and address registers update once per word,
// so throughput is one word per cycle, limited only by the result consumer; a stalled output
// holds one word in the input register and one in the output register before ready falls.
module vram_hdma_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  vhdma_in_if.sink    in_ch,
  vhdma_out_if.source out_ch
);

  logic             in_valid_r;
  vhdma_pkg::item_t in_item_r;
  vhdma_pkg::cfg_t  cfg_r;
  vhdma_pkg::res_t  res;
  logic             can_load;
  logic             advance;

  assign advance     = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_mode   <= 1'b1;
      cfg_r.double_speed <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        vhdma_pkg::CFG_COLOR_MODE:   cfg_r.color_mode   <= cfg_data;
        vhdma_pkg::CFG_DOUBLE_SPEED: cfg_r.double_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.command <= in_ch.command;
      in_item_r.data    <= in_ch.data;
    end
  end

  vhdma_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  vhdma_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  a_req_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.transfer_valid) |->
      (out_ch.length_bytes != 12'd0 && out_ch.length_bytes[3:0] == 4'd0 &&
       out_ch.src_addr[3:0] == 4'd0 && out_ch.dst_offset[3:0] == 4'd0))
    else $error("copy request misaligned or empty");

  a_no_req : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.transfer_valid) |->
      (out_ch.length_bytes == 12'd0 && out_ch.cycles_added == 12'd0))
    else $error("charge without copy request");

  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages full");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("buffered word dropped");

endmodule

// ===== sv/vhdma_core.sv =====
module vhdma_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  vhdma_pkg::item_t  item,
  input  vhdma_pkg::cfg_t   cfg,
  output vhdma_pkg::res_t   res
);

  logic [7:0] src_hi_r, src_lo_r, dst_hi_r, dst_lo_r, status_r;
  logic       armed_r;
  logic [7:0] src_hi_nxt, src_lo_nxt, dst_hi_nxt, dst_lo_nxt, status_nxt;
  logic       armed_nxt;

  logic        req;
  logic [7:0]  blocks;
  logic [11:0] len;
  logic [15:0] src16;
  logic [12:0] dst13;
  logic [15:0] src_end;
  logic [13:0] dst_end;
  logic [7:0]  status_dec;
  logic        data_blank;

  assign src16      = {src_hi_r, src_lo_r & vhdma_pkg::NIB_MASK};
  assign dst13      = {dst_hi_r[4:0], dst_lo_r & vhdma_pkg::NIB_MASK};
  assign len        = {blocks, 4'b0000};
  assign src_end    = src16 + {4'b0000, len};
  assign dst_end    = {1'b0, dst13} + {2'b00, len};
  assign status_dec = status_r - 8'd1;
  assign data_blank = (item.data & vhdma_pkg::BLANK_MODE) != 8'd0;

  always_comb begin
    req        = 1'b0;
    blocks     = 8'd1;
    status_nxt = status_r;
    armed_nxt  = armed_r;
    case (vhdma_pkg::cmd_t'(item.command))
      vhdma_pkg::CMD_LENGTH: begin
        if (!cfg.color_mode) begin
          status_nxt = item.data;
        end else if (armed_r && !data_blank) begin
          armed_nxt  = 1'b0;
          status_nxt = status_r | vhdma_pkg::BLANK_MODE;
        end else if (!data_blank) begin
          req        = 1'b1;
          blocks     = (item.data & vhdma_pkg::LEN_MASK) + 8'd1;
          status_nxt = vhdma_pkg::STATUS_IDLE;
          armed_nxt  = 1'b0;
        end else begin
          armed_nxt  = 1'b1;
          status_nxt = item.data & vhdma_pkg::LEN_MASK;
        end
      end
      vhdma_pkg::CMD_TICK: begin
        if (armed_r) begin
          req = 1'b1;
          if ((status_dec & vhdma_pkg::LEN_MASK) == vhdma_pkg::LEN_MASK) begin
            armed_nxt  = 1'b0;
            status_nxt = vhdma_pkg::STATUS_IDLE;
          end else begin
            status_nxt = status_dec;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    src_hi_nxt = src_hi_r;
    src_lo_nxt = src_lo_r;
    dst_hi_nxt = dst_hi_r;
    dst_lo_nxt = dst_lo_r;
    if (req) begin
      src_hi_nxt = src_end[15:8];
      src_lo_nxt = src_end[7:0] & vhdma_pkg::NIB_MASK;
      dst_hi_nxt = {2'b00, dst_end[13:8]};
      dst_lo_nxt = dst_end[7:0] & vhdma_pkg::NIB_MASK;
    end else begin
      case (vhdma_pkg::cmd_t'(item.command))
        vhdma_pkg::CMD_SRC_HI: src_hi_nxt = item.data;
        vhdma_pkg::CMD_SRC_LO: src_lo_nxt = item.data;
        vhdma_pkg::CMD_DST_HI: dst_hi_nxt = item.data;
        vhdma_pkg::CMD_DST_LO: dst_lo_nxt = item.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    res                = '0;
    res.transfer_valid = req;
    if (req) begin
      res.src_addr     = src16;
      res.dst_offset   = dst13;
      res.length_bytes = len;
      res.cycles_added = vhdma_pkg::charge(blocks, cfg.double_speed);
    end
    res.status_byte = status_nxt;
    res.busy_res    = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_hi_r <= 8'd0;
      src_lo_r <= 8'd0;
      dst_hi_r <= 8'd0;
      dst_lo_r <= 8'd0;
      status_r <= vhdma_pkg::STATUS_IDLE;
      armed_r  <= 1'b0;
    end else if (advance) begin
      src_hi_r <= src_hi_nxt;
      src_lo_r <= src_lo_nxt;
      dst_hi_r <= dst_hi_nxt;
      dst_lo_r <= dst_lo_nxt;
      status_r <= status_nxt;
      armed_r  <= armed_nxt;
    end
  end

endmodule

// ===== sv/vhdma_out_reg.sv =====
module vhdma_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  vhdma_pkg::res_t res,
  output logic            can_load,
  vhdma_out_if.source     out_ch
);

  logic            valid_r;
  vhdma_pkg::res_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.transfer_valid = res_r.transfer_valid;
  assign out_ch.src_addr       = res_r.src_addr;
  assign out_ch.dst_offset     = res_r.dst_offset;
  assign out_ch.length_bytes   = res_r.length_bytes;
  assign out_ch.cycles_added   = res_r.cycles_added;
  assign out_ch.status_byte    = res_r.status_byte;
  assign out_ch.busy_res       = res_r.busy_res;

endmodule

// ===== tb/tb_vram_hdma_controller.sv =====
`timescale 1ns / 100ps

module tb_vram_hdma_controller;
  import vhdma_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 80;
  localparam int WORDS_PER_RUN = 190;
  localparam int NUM_RUNS      = 5;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] dat;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  vhdma_in_if  in_ch();
  vhdma_out_if out_ch();

  vram_hdma_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block's registers
  logic [7:0] sh_src_hi, sh_src_lo, sh_dst_hi, sh_dst_lo, sh_len_status;
  logic       sh_armed, sh_color, sh_double;

  res_t      transfers_due[$];
  stim_row_t stim_tab[$];
  int        errors;
  int        words_sent;
  int        cyc_count;
  bit        idle_on;
  int        long_hold_asks;
  bit        run_color [NUM_RUNS] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  bit        run_double[NUM_RUNS] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  function automatic res_t issue_copy(input logic [11:0] nbytes);
    res_t        r;
    logic [15:0] src, dst, src_end, dst_end, cyc;
    r       = '0;
    src     = {sh_src_hi, sh_src_lo & NIB_MASK};
    dst     = {sh_dst_hi & BANK_MASK, sh_dst_lo & NIB_MASK};
    src_end = src + 16'(nbytes);
    dst_end = dst + 16'(nbytes);
    cyc     = 16'(CYCLES_PER_BLOCK) * 16'(nbytes >> 4);
    if (sh_double) cyc = cyc << 1;
    r.transfer_valid = 1'b1;
    r.src_addr       = src;
    r.dst_offset     = dst[12:0];
    r.length_bytes   = nbytes;
    r.cycles_added   = (cyc > 16'(MAX_CYCLES)) ? 12'hFFF : cyc[11:0];
    sh_src_hi = src_end[15:8];
    sh_src_lo = src_end[7:0] & NIB_MASK;
    sh_dst_hi = dst_end[15:8];
    sh_dst_lo = dst_end[7:0] & NIB_MASK;
    return r;
  endfunction

  function automatic res_t predict_transfer(input logic [2:0] cmd, input logic [7:0] dat);
    res_t r;
    r = '0;
    case (cmd)
      CMD_SRC_HI: sh_src_hi = dat;
      CMD_SRC_LO: sh_src_lo = dat;
      CMD_DST_HI: sh_dst_hi = dat;
      CMD_DST_LO: sh_dst_lo = dat;
      CMD_LENGTH: begin
        if (!sh_color) begin
          sh_len_status = dat;
        end else if (sh_armed && !dat[7]) begin
          sh_armed      = 1'b0;
          sh_len_status = sh_len_status | BLANK_MODE;
        end else if (!dat[7]) begin
          r             = issue_copy(({5'd0, dat[6:0]} + 12'd1) << 4);
          sh_len_status = STATUS_IDLE;
          sh_armed      = 1'b0;
        end else begin
          sh_armed      = 1'b1;
          sh_len_status = dat & LEN_MASK;
        end
      end
      CMD_TICK: begin
        if (sh_armed) begin
          r             = issue_copy(12'd16);
          sh_len_status = sh_len_status - 8'd1;
          if ((sh_len_status & LEN_MASK) == LEN_MASK) begin
            sh_armed      = 1'b0;
            sh_len_status = STATUS_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.status_byte = sh_len_status;
    r.busy_res    = sh_armed;
    return r;
  endfunction

  function automatic res_t mk_res(input logic tv, input logic [15:0] src,
                                  input logic [12:0] dst, input logic [11:0] len,
                                  input logic [11:0] cyc, input logic [7:0] st,
                                  input logic busy);
    res_t r;
    r.transfer_valid = tv;
    r.src_addr       = src;
    r.dst_offset     = dst;
    r.length_bytes   = len;
    r.cycles_added   = cyc;
    r.status_byte    = st;
    r.busy_res       = busy;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic add_row(input logic [2:0] cmd, input logic [7:0] dat,
                         input bit typed, input res_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.dat   = dat;
    row.typed = typed;
    row.want  = want;
    stim_tab.push_back(row);
  endtask

  task automatic send_word(input logic [2:0] cmd, input logic [7:0] dat,
                           input bit typed = 1'b0, input res_t want = '0);
    int   gap;
    res_t pred;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.command = cmd;
    in_ch.data    = dat;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_transfer(cmd, dat);
    transfers_due.push_back(typed ? want : pred);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (transfers_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input bit color, input bit dbl);
    drain();
    cfg_we    = 1'b1;
    cfg_index = CFG_COLOR_MODE;
    cfg_data  = color;
    @(negedge clk);
    cfg_index = CFG_DOUBLE_SPEED;
    cfg_data  = dbl;
    @(negedge clk);
    cfg_we    = 1'b0;
    sh_color  = color;
    sh_double = dbl;
  endtask

  task automatic random_burst();
    int         kind, ticks, r;
    logic [6:0] blocks;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      repeat ($urandom_range(1, 6)) send_word(3'($urandom_range(0, 7)), 8'($urandom));
    end else begin
      if ($urandom_range(0, 3) != 0) send_word(CMD_SRC_HI, 8'($urandom));
      if ($urandom_range(0, 3) != 0) send_word(CMD_SRC_LO, 8'($urandom));
      if ($urandom_range(0, 3) != 0) send_word(CMD_DST_HI, 8'($urandom));
      if ($urandom_range(0, 3) != 0) send_word(CMD_DST_LO, 8'($urandom));
      blocks = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6));
      if (kind < 5) begin
        send_word(CMD_LENGTH, {1'b0, blocks});
      end else begin
        send_word(CMD_LENGTH, {1'b1, blocks});
        ticks = $urandom_range(0, (blocks > 7'd30) ? 32 : int'(blocks) + 2);
        repeat (ticks) begin
          r = $urandom_range(0, 29);
          if (r == 0) send_word(CMD_LENGTH, 8'($urandom));
          else if (r == 1) send_word(3'($urandom_range(0, 3)), 8'($urandom));
          else send_word(CMD_TICK, 8'($urandom));
        end
      end
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // result side: random stalls, plus a long hold on request
  initial begin
    int rx_hold;
    int holds_done;
    rx_hold      = 0;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (holds_done != long_hold_asks) begin
        out_ch.ready = 1'b0;
        rx_hold      = LONG_HOLD - 1;
        holds_done   = long_hold_asks;
      end else begin
        out_ch.ready = 1'b1;
        if (idle_on) rx_hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (transfers_due.size() == 0) begin
        $display("%0t: result word with nothing expected, got status %0h", $time,
                 out_ch.status_byte);
        errors++;
      end else begin
        want = transfers_due.pop_front();
        check_field("transfer_valid", want.transfer_valid, out_ch.transfer_valid);
        check_field("src_addr", want.src_addr, out_ch.src_addr);
        check_field("dst_offset", want.dst_offset, out_ch.dst_offset);
        check_field("length_bytes", want.length_bytes, out_ch.length_bytes);
        check_field("cycles_added", want.cycles_added, out_ch.cycles_added);
        check_field("status_byte", want.status_byte, out_ch.status_byte);
        check_field("busy_res", want.busy_res, out_ch.busy_res);
      end
    end
  end

  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    res_t idle_ff;
    int   start;
    errors         = 0;
    words_sent     = 0;
    cyc_count      = 0;
    long_hold_asks = 0;
    idle_on        = 1'b1;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = 1'b0;
    cfg_data       = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = '0;
    in_ch.data     = '0;
    sh_src_hi      = '0;
    sh_src_lo      = '0;
    sh_dst_hi      = '0;
    sh_dst_lo      = '0;
    sh_len_status  = STATUS_IDLE;
    sh_armed       = 1'b0;
    sh_color       = 1'b1;
    sh_double      = 1'b0;
    idle_ff        = mk_res(1'b0, '0, '0, '0, '0, STATUS_IDLE, 1'b0);

    add_row(CMD_TICK,    8'h00, 1'b1, idle_ff);
    add_row(CMD_SPARE_6, 8'hFF, 1'b1, idle_ff);
    add_row(CMD_SPARE_7, 8'h5A, 1'b1, idle_ff);
    add_row(CMD_SRC_HI,  8'hFF, 1'b1, idle_ff);
    add_row(CMD_SRC_LO,  8'hFF, 1'b1, idle_ff);
    add_row(CMD_DST_HI,  8'hFF, 1'b1, idle_ff);
    add_row(CMD_DST_LO,  8'hFF, 1'b1, idle_ff);
    add_row(CMD_LENGTH,  8'h7F, 1'b1,
            mk_res(1'b1, 16'hFFF0, 13'h1FF0, 12'h800, 12'h400, STATUS_IDLE, 1'b0));
    add_row(CMD_LENGTH,  8'h00, 1'b0, '0);
    add_row(CMD_SRC_HI,  8'h00, 1'b1, idle_ff);
    add_row(CMD_SRC_LO,  8'h00, 1'b1, idle_ff);
    add_row(CMD_DST_HI,  8'h00, 1'b1, idle_ff);
    add_row(CMD_DST_LO,  8'h0F, 1'b1, idle_ff);
    add_row(CMD_LENGTH,  8'h82, 1'b1, mk_res(1'b0, '0, '0, '0, '0, 8'h02, 1'b1));
    add_row(CMD_TICK,    8'hFF, 1'b0, '0);
    add_row(CMD_TICK,    8'h00, 1'b0, '0);
    add_row(CMD_TICK,    8'h00, 1'b0, '0);
    add_row(CMD_TICK,    8'h00, 1'b1, idle_ff);
    add_row(CMD_LENGTH,  8'hFF, 1'b1, mk_res(1'b0, '0, '0, '0, '0, 8'h7F, 1'b1));
    add_row(CMD_TICK,    8'h00, 1'b0, '0);
    add_row(CMD_LENGTH,  8'h85, 1'b1, mk_res(1'b0, '0, '0, '0, '0, 8'h05, 1'b1));
    add_row(CMD_LENGTH,  8'h03, 1'b1, mk_res(1'b0, '0, '0, '0, '0, 8'h85, 1'b0));
    add_row(CMD_TICK,    8'h00, 1'b1, mk_res(1'b0, '0, '0, '0, '0, 8'h85, 1'b0));
    add_row(CMD_LENGTH,  8'h80, 1'b1, mk_res(1'b0, '0, '0, '0, '0, 8'h00, 1'b1));
    add_row(CMD_TICK,    8'h00, 1'b0, '0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_tab[i]) send_word(stim_tab[i].cmd, stim_tab[i].dat, stim_tab[i].typed,
                                    stim_tab[i].want);

    for (int run = 0; run < NUM_RUNS; run++) begin
      // in color mode, leave a run armed across the mode change
      send_word(CMD_LENGTH, {1'b1, 7'($urandom_range(2, 9))});
      set_mode(run_color[run], run_double[run]);
      idle_on = (run != 0);
      if (run == 2) long_hold_asks++;
      start = words_sent;
      while (words_sent < start + WORDS_PER_RUN) random_burst();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vhdma_pkg.sv
sv/vhdma_if.sv
sv/vhdma_core.sv
sv/vhdma_out_reg.sv
sv/vram_hdma_controller.sv
tb/tb_vram_hdma_controller.sv
